FILE: hw/rtl/sfpw_pkg.sv
// shared constants, types and pointer helpers for the sample fifo with peek window
package sfpw_pkg;

  localparam int unsigned CAPACITY = 64;

  localparam int unsigned PTR_W  = $clog2(2 * CAPACITY);
  localparam int unsigned SLOT_W = $clog2(CAPACITY);
  localparam int unsigned OCC_W  = $clog2(CAPACITY + 1);
  localparam int unsigned WIN_W  = 8;
  localparam int unsigned FLD_W  = 16;
  localparam int unsigned CNT_W  = 32;

  localparam int unsigned MOTION_W = 3 * FLD_W;
  localparam int unsigned RATE_W   = 4 * FLD_W;
  localparam int unsigned SAMPLE_W = MOTION_W + RATE_W;

  localparam int unsigned IN_DATA_W  = ((SAMPLE_W + WIN_W + 7) / 8) * 8;
  localparam int unsigned OUT_BITS   = SAMPLE_W + OCC_W + 2 * CNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    KIND_PUSH    = 2'd0,
    KIND_POP     = 2'd1,
    KIND_PEEK    = 2'd2,
    KIND_ADVANCE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_SHORT     = 2'd2,
    STAT_BAD_COUNT = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } state_e;

  // pointers run modulo 2*CAPACITY, k is at most CAPACITY
  function automatic logic [PTR_W-1:0] ptr_add(logic [PTR_W-1:0] p, logic [OCC_W-1:0] k);
    logic [PTR_W:0] sum;
    sum = {1'b0, p} + (PTR_W + 1)'(k);
    if (sum >= (PTR_W + 1)'(2 * CAPACITY)) begin
      sum = sum - (PTR_W + 1)'(2 * CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

  // slot of pointer p plus offset k (k below CAPACITY)
  function automatic logic [SLOT_W-1:0] slot_of(logic [PTR_W-1:0] p, logic [OCC_W-1:0] k);
    logic [PTR_W:0] sum;
    sum = {1'b0, p} + (PTR_W + 1)'(k);
    if (sum >= (PTR_W + 1)'(2 * CAPACITY)) begin
      sum = sum - (PTR_W + 1)'(2 * CAPACITY);
    end
    if (sum >= (PTR_W + 1)'(CAPACITY)) begin
      sum = sum - (PTR_W + 1)'(CAPACITY);
    end
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [OCC_W-1:0] occ_of(logic [PTR_W-1:0] wp, logic [PTR_W-1:0] rp);
    logic [PTR_W:0] diff;
    if (wp >= rp) begin
      diff = {1'b0, wp} - {1'b0, rp};
    end else begin
      diff = {1'b0, wp} + (PTR_W + 1)'(2 * CAPACITY) - {1'b0, rp};
    end
    return OCC_W'(diff);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + CNT_W'(1);
  endfunction

endpackage

FILE: hw/rtl/sample_fifo_with_peek_window_top.sv
// sample fifo with peek window: control, pointers, counters and output register
//
// A first-in first-out store of up to 64 seven-field motion samples, kept in two
// memories with a registered read. The input tuser selects push, pop, peek window
// or advance. Push, advance and every error answer produce their one item in the
// cycle after acceptance. A pop's item and the n items of a peek of n pass from
// the memory read register through the output register, the peek items one per
// cycle while the output is taken. A new input item is taken once the block is
// idle and the output register is free or being emptied. Every output item carries
// the occupancy after the command and the saturating push and drop counts.
module sample_fifo_with_peek_window_top
  import sfpw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // accel_x, accel_y, accel_z, temperature, gyro_x, gyro_y, gyro_z, window_count
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_accel_x, out_accel_y, out_accel_z, out_temperature, out_gyro_x,
  // out_gyro_y, out_gyro_z, occupancy, pushes_total, drops_total, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [1:0]            m_axis_tuser,
  output logic                  m_axis_tlast
);

  state_e            state_q, state_d;
  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0]  push_q, push_d, drop_q, drop_d;
  logic [OCC_W-1:0]  issue_idx_q, issue_idx_d, total_q, total_d;
  logic              rd_pend_q, rd_pend_d, rd_last_q, rd_last_d;

  logic              m_valid_q, m_valid_d;
  status_e           m_status_q;
  logic              m_last_q;
  logic [SAMPLE_W-1:0] m_sample_q;
  logic [OCC_W-1:0]  m_occ_q;
  logic [CNT_W-1:0]  m_push_q, m_drop_q;

  kind_e             kind;
  logic [WIN_W-1:0]  win;
  logic [MOTION_W-1:0] in_motion, rd_motion;
  logic [RATE_W-1:0]   in_rate, rd_rate;
  logic [OCC_W-1:0]  count;
  logic              out_free, accept, can_load, issue_more;

  logic              load, load_sample, load_last;
  status_e           load_status;
  logic              wr_en, rd_en;
  logic [SLOT_W-1:0] rd_addr;

  assign kind      = kind_e'(s_axis_tuser);
  assign in_motion = s_axis_tdata[MOTION_W-1:0];
  assign in_rate   = s_axis_tdata[SAMPLE_W-1:MOTION_W];
  assign win       = s_axis_tdata[SAMPLE_W+WIN_W-1:SAMPLE_W];

  assign count    = occ_of(wp_q, rp_q);
  assign out_free = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign can_load = (state_q == S_STREAM) && rd_pend_q && out_free;
  assign issue_more = (issue_idx_q != total_q) && (!rd_pend_q || can_load);

  sfpw_ram #(
    .WIDTH(MOTION_W),
    .DEPTH(CAPACITY)
  ) u_motion_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(slot_of(wp_q, '0)),
    .wdata_i(in_motion),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_motion)
  );

  sfpw_ram #(
    .WIDTH(RATE_W),
    .DEPTH(CAPACITY)
  ) u_rate_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(slot_of(wp_q, '0)),
    .wdata_i(in_rate),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_rate)
  );

  // writes happen only in idle and reads of a slot come in a later cycle,
  // so the memories never see a read and a write of one entry in the same cycle
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    push_d      = push_q;
    drop_d      = drop_q;
    issue_idx_d = issue_idx_q;
    total_d     = total_q;
    rd_pend_d   = rd_pend_q;
    rd_last_d   = rd_last_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    load        = 1'b0;
    load_sample = 1'b0;
    load_last   = 1'b1;
    load_status = STAT_OK;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = slot_of(rp_q, issue_idx_q);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_PUSH: begin
              load = 1'b1;
              if (count >= OCC_W'(CAPACITY)) begin
                drop_d      = sat_inc(drop_q);
                load_status = STAT_FULL;
              end else begin
                wr_en  = 1'b1;
                wp_d   = ptr_add(wp_q, OCC_W'(1));
                push_d = sat_inc(push_q);
              end
            end
            KIND_POP: begin
              if (count == '0) begin
                load        = 1'b1;
                load_status = STAT_SHORT;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = slot_of(rp_q, '0);
                rp_d        = ptr_add(rp_q, OCC_W'(1));
                issue_idx_d = OCC_W'(1);
                total_d     = OCC_W'(1);
                rd_pend_d   = 1'b1;
                rd_last_d   = 1'b1;
                state_d     = S_STREAM;
              end
            end
            default: begin
              if (win == '0 || win > WIN_W'(CAPACITY)) begin
                load        = 1'b1;
                load_status = STAT_BAD_COUNT;
              end else if (WIN_W'(count) < win) begin
                load        = 1'b1;
                load_status = STAT_SHORT;
              end else if (kind == KIND_PEEK) begin
                rd_en       = 1'b1;
                rd_addr     = slot_of(rp_q, '0);
                issue_idx_d = OCC_W'(1);
                total_d     = OCC_W'(win);
                rd_pend_d   = 1'b1;
                rd_last_d   = (win == WIN_W'(1));
                state_d     = S_STREAM;
              end else begin
                load = 1'b1;
                rp_d = ptr_add(rp_q, OCC_W'(win));
              end
            end
          endcase
        end
      end
      S_STREAM: begin
        if (can_load) begin
          load        = 1'b1;
          load_sample = 1'b1;
          load_last   = rd_last_q;
        end
        if (issue_more) begin
          rd_en       = 1'b1;
          issue_idx_d = issue_idx_q + OCC_W'(1);
          rd_pend_d   = 1'b1;
          rd_last_d   = (issue_idx_q + OCC_W'(1) == total_q);
        end else if (can_load) begin
          rd_pend_d = 1'b0;
        end
        if (can_load && rd_last_q) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      push_q      <= '0;
      drop_q      <= '0;
      issue_idx_q <= '0;
      total_q     <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      push_q      <= push_d;
      drop_q      <= drop_d;
      issue_idx_q <= issue_idx_d;
      total_q     <= total_d;
      rd_pend_q   <= rd_pend_d;
      rd_last_q   <= rd_last_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // output payload, loaded with the state as it stands after the command
  always_ff @(posedge clk_i) begin
    if (load) begin
      m_status_q <= load_status;
      m_last_q   <= load_last;
      m_sample_q <= load_sample ? {rd_rate, rd_motion} : '0;
      m_occ_q    <= occ_of(wp_d, rp_d);
      m_push_q   <= push_d;
      m_drop_q   <= drop_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = OUT_DATA_W'({m_drop_q, m_push_q, m_occ_q, m_sample_q});

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_of(wp_q, rp_q) <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !rd_pend_q)
    else $error("read pending while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STREAM) |-> (!wr_en && wp_q == $past(wp_q)))
    else $error("write during stream");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != STAT_OK) |-> m_axis_tlast)
    else $error("error item without last");

endmodule

FILE: hw/rtl/sfpw_ram.sv
// generic simple dual-port ram with registered read
module sfpw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
